[hw/rtl/lru_key_value_cache_unit_macros.svh]
// ----------------------------------------------------------------------------
// lru key-value cache assertion macros
// shared property wrappers for the checker, clocked on the rising edge and
// quiet while reset is asserted
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

// condition must hold on every edge out of reset
`define LRUKV_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lru cache check failed");

// signal holds its value on the edge after the condition
`define LRUKV_ASSERT_HOLD(name, clk, rst_n, cond, sig) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("lru cache word changed while stalled");

`endif

[hw/rtl/lrukv_pkg.sv]
// ----------------------------------------------------------------------------
// lrukv_pkg
// shared widths, codes and word types of the lru key-value cache
// ----------------------------------------------------------------------------
package lrukv_pkg;

  localparam int ENTRIES_DEFAULT = 16;
  localparam int KEY_W           = 16;
  localparam int VALUE_W         = 32;
  localparam int CAP_W           = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } lrukv_op_e;

  typedef struct packed {
    lrukv_op_e                  op;
    logic [KEY_W-1:0]           key;
    logic signed [VALUE_W-1:0]  value;
  } lrukv_req_t;

  typedef struct packed {
    logic                       found;
    logic signed [VALUE_W-1:0]  read_value;
    logic                       evicted;
    logic [KEY_W-1:0]           evicted_key;
  } lrukv_res_t;

endpackage

[hw/rtl/lru_key_value_cache_unit.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o with operation_i (get or put),
// key_i and value_i. output channel: out_valid_o / out_stall_i with found_o,
// read_value_o, evicted_o and evicted_key_o, one result word per input word.
// a word is taken on a rising edge with valid high and stall low.
// throughput: one word per cycle while out_stall_i is low; the key match
// against all ENTRIES slots, the rank update and the store write sit between
// the input register and the result register, so the next word always sees
// the updated store. capacity must be written through cfg_we_i / cfg_wdata_i
// only while the unit is idle, by the user; the unit does not enforce it.
// zero acts as one and values above ENTRIES act as ENTRIES.
// reset empties the cache at once and sets capacity to 16; no clearing pass.
// when out_stall_i holds a result, one more word may wait in the input
// register, after which in_stall_o rises in the same cycle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit #(
  parameter int ENTRIES = lrukv_pkg::ENTRIES_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic [lrukv_pkg::KEY_W-1:0]         key_i,
  input  logic signed [lrukv_pkg::VALUE_W-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                found_o,
  output logic signed [lrukv_pkg::VALUE_W-1:0] read_value_o,
  output logic                                evicted_o,
  output logic [lrukv_pkg::KEY_W-1:0]         evicted_key_o,
  input  logic                                cfg_we_i,
  input  logic [lrukv_pkg::CAP_W-1:0]         cfg_wdata_i
);
  import lrukv_pkg::*;

  logic [CAP_W-1:0] cap_q;
  logic             in_valid_q;
  lrukv_req_t       req_q;
  logic             out_valid_q;
  lrukv_res_t       res_q;
  lrukv_res_t       res_d;
  logic             advance;
  logic             in_accept;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.op    <= lrukv_op_e'(operation_i);
      req_q.key   <= key_i;
      req_q.value <= value_i;
    end
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  lrukv_core #(
    .Entries (ENTRIES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cap_i    (cap_q),
    .req_en_i (advance && in_valid_q),
    .req_i    (req_q),
    .res_o    (res_d)
  );

  assign out_valid_o   = out_valid_q;
  assign found_o       = res_q.found;
  assign read_value_o  = res_q.read_value;
  assign evicted_o     = res_q.evicted;
  assign evicted_key_o = res_q.evicted_key;

endmodule

[hw/rtl/lrukv_core.sv]
// ----------------------------------------------------------------------------
// lrukv_core
// entry store with parallel key match, recency ranks and replacement choice;
// gives the result of the pending word and updates the store when it moves on
// ----------------------------------------------------------------------------
module lrukv_core #(
  parameter int Entries = lrukv_pkg::ENTRIES_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lrukv_pkg::CAP_W-1:0]   cap_i,
  input  logic                          req_en_i,
  input  lrukv_pkg::lrukv_req_t         req_i,
  output lrukv_pkg::lrukv_res_t         res_o
);
  import lrukv_pkg::*;

  localparam int IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int OccW = $clog2(Entries + 1);
  localparam int CmpW = (OccW > CAP_W) ? OccW : CAP_W;

  logic [KEY_W-1:0]          key_q   [Entries];
  logic signed [VALUE_W-1:0] value_q [Entries];
  logic [Entries-1:0]        valid_q;
  logic [IdxW-1:0]           rank_q  [Entries];
  logic [OccW-1:0]           occ_q;

  logic              hit;
  logic [IdxW-1:0]   hit_idx;
  logic              free_any;
  logic [IdxW-1:0]   free_idx;
  logic [IdxW-1:0]   lru_idx;
  logic [OccW-1:0]   occ_m1;
  logic [IdxW-1:0]   lru_rank;
  logic              is_put;
  logic              room;
  logic              fill;
  logic [IdxW-1:0]   slot;
  logic [IdxW-1:0]   prom_rank;
  logic              upd;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    lru_idx  = '0;
    occ_m1   = occ_q - OccW'(1);
    lru_rank = occ_m1[IdxW-1:0];
    for (int i = Entries - 1; i >= 0; i--) begin
      if (valid_q[i] && key_q[i] == req_i.key) begin
        hit     = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
      if (valid_q[i] && rank_q[i] == lru_rank) begin
        lru_idx = IdxW'(i);
      end
    end
    is_put    = (req_i.op == OP_PUT);
    room      = free_any && (occ_q == '0 || CmpW'(occ_q) < CmpW'(cap_i));
    fill      = is_put && !hit && room;
    slot      = hit ? hit_idx : (fill ? free_idx : lru_idx);
    prom_rank = hit ? rank_q[hit_idx] : lru_rank;
    upd       = req_en_i && (hit || is_put);

    res_o.found       = hit;
    res_o.read_value  = (hit && req_i.op == OP_GET) ? value_q[hit_idx] : '0;
    res_o.evicted     = is_put && !hit && !fill;
    res_o.evicted_key = (is_put && !hit && !fill) ? key_q[lru_idx] : '0;
  end

  // recency ranks, valid bits and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < Entries; i++) begin
        rank_q[i] <= '0;
      end
    end else if (upd) begin
      for (int i = 0; i < Entries; i++) begin
        if (IdxW'(i) == slot) begin
          rank_q[i] <= '0;
        end else if (valid_q[i] && (fill || rank_q[i] < prom_rank)) begin
          rank_q[i] <= rank_q[i] + IdxW'(1);
        end
      end
      if (fill) begin
        valid_q[slot] <= 1'b1;
        occ_q         <= occ_q + OccW'(1);
      end
    end
  end

  // key and value store
  always_ff @(posedge clk_i) begin
    if (req_en_i && is_put) begin
      key_q[slot]   <= req_i.key;
      value_q[slot] <= req_i.value;
    end
  end

endmodule

[hw/rtl/lrukv_checker.sv]
// ----------------------------------------------------------------------------
// lrukv_checker
// port-level checks on the result channel of the lru key-value cache
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_unit_macros.svh"

module lrukv_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic                                 found_o,
  input logic signed [lrukv_pkg::VALUE_W-1:0] read_value_o,
  input logic                                 evicted_o,
  input logic [lrukv_pkg::KEY_W-1:0]          evicted_key_o
);

  `LRUKV_ASSERT(a_valid_held, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)
  `LRUKV_ASSERT_HOLD(a_evkey_held, clk_i, rst_ni, out_valid_o && out_stall_i, evicted_key_o)
  `LRUKV_ASSERT(a_hit_no_evict, clk_i, rst_ni, out_valid_o && found_o |-> !evicted_o)
  `LRUKV_ASSERT(a_evkey_zero, clk_i, rst_ni, out_valid_o && !evicted_o |-> evicted_key_o == '0)
  `LRUKV_ASSERT(a_value_hit, clk_i, rst_ni, out_valid_o && read_value_o != '0 |-> found_o)

endmodule

bind lru_key_value_cache_unit lrukv_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .found_o       (found_o),
  .read_value_o  (read_value_o),
  .evicted_o     (evicted_o),
  .evicted_key_o (evicted_key_o)
);
